// ===== rtl/irange_pkg.sv =====
// ----------------------------------------------------------------------------
// irange_pkg: shared types and constants for the interval range alu
// word and lane types, operation codes and the divider pipeline depth
// ----------------------------------------------------------------------------
package irange_pkg;

  localparam int WORD       = 32;
  localparam int LANES      = 4;
  localparam int DIV_STAGES = WORD;

  typedef logic [WORD-1:0] word_t;
  typedef word_t [LANES-1:0] lane_word_t;

  localparam word_t ONE  = word_t'(1);
  localparam word_t ZERO = word_t'(0);

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  // sideband that travels next to the divider pipeline
  typedef struct packed {
    cmd_t             cmd;
    logic             rn;
    logic             dz;
    word_t            rl;
    word_t            ru;
    lane_word_t       prod;
    logic [LANES-1:0] neg;
  } side_t;

endpackage

// ===== rtl/irange_div.sv =====
// ----------------------------------------------------------------------------
// irange_div: pipelined unsigned divider, four lanes
// restoring division, one quotient bit per stage, WORD stages
// ----------------------------------------------------------------------------
module irange_div (
  input  logic                   clk,
  input  logic                   en,
  input  irange_pkg::lane_word_t dvd_i,
  input  irange_pkg::lane_word_t dvs_i,
  output irange_pkg::lane_word_t quo_o
);

  irange_pkg::lane_word_t rem_r [irange_pkg::DIV_STAGES];
  irange_pkg::lane_word_t num_r [irange_pkg::DIV_STAGES];
  irange_pkg::lane_word_t dvs_r [irange_pkg::DIV_STAGES];

  for (genvar s = 0; s < irange_pkg::DIV_STAGES; s++) begin : g_stage
    irange_pkg::lane_word_t rem_in, num_in, dvs_in, rem_nxt, num_nxt;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = dvd_i;
      assign dvs_in = dvs_i;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign num_in = num_r[s-1];
      assign dvs_in = dvs_r[s-1];
    end

    always_comb begin
      logic [irange_pkg::WORD:0] t_v;
      logic [irange_pkg::WORD:0] d_v;
      for (int l = 0; l < irange_pkg::LANES; l++) begin
        t_v = {rem_in[l], num_in[l][irange_pkg::WORD-1]};
        d_v = t_v - {1'b0, dvs_in[l]};
        if (t_v >= {1'b0, dvs_in[l]}) begin
          rem_nxt[l] = d_v[irange_pkg::WORD-1:0];
          num_nxt[l] = {num_in[l][irange_pkg::WORD-2:0], 1'b1};
        end else begin
          rem_nxt[l] = t_v[irange_pkg::WORD-1:0];
          num_nxt[l] = {num_in[l][irange_pkg::WORD-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        num_r[s] <= num_nxt;
        dvs_r[s] <= dvs_in;
      end
    end
  end

  // dividend bits shift out as quotient bits shift in
  assign quo_o = num_r[irange_pkg::DIV_STAGES-1];

endmodule

// ===== rtl/interval_range_alu_core.sv =====
// ----------------------------------------------------------------------------
// interval_range_alu_core: add, subtract, multiply, divide on integer ranges
// corner products and quotients reduced to min and max+1, results wrap
// ----------------------------------------------------------------------------
// every command passes stages a, b, c, divider stages d, then e, f and g to out_tvalid
// throughput: one transaction per cycle; the 32-stage divider sets the depth
// a stall at the output freezes the whole pipeline, nothing is dropped
// reset: synchronous active-low rst_n clears all valid bits, payload not reset
// ----------------------------------------------------------------------------
module interval_range_alu_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // a_null, a_lower[32:1], a_upper[64:33], b_null, b_lower[97:66], b_upper[129:98]
  input  logic [135:0] in_tdata,
  // command
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // res_null, res_lower[32:1], res_upper[64:33], div_zero[65]
  output logic [71:0]  out_tdata
);

  typedef struct packed {
    logic                  arith;
    logic                  rn;
    logic                  dz;
    irange_pkg::word_t     rl;
    irange_pkg::word_t     ru;
  } fin_t;

  // global advance: pipeline moves when the output slot is free or taken
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---- stage a: input registers
  logic              v_a_r;
  irange_pkg::cmd_t  cmd_a_r;
  logic              an_a_r, bn_a_r;
  irange_pkg::word_t al_a_r, au_a_r, bl_a_r, bu_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
    end else if (en) begin
      v_a_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd_a_r <= irange_pkg::cmd_t'(in_tuser);
      an_a_r  <= in_tdata[0];
      al_a_r  <= in_tdata[32:1];
      au_a_r  <= in_tdata[64:33];
      bn_a_r  <= in_tdata[65];
      bl_a_r  <= in_tdata[97:66];
      bu_a_r  <= in_tdata[129:98];
    end
  end

  // ---- stage b: add/sub result, null rules, corner operands
  irange_pkg::word_t x1, y1, rl_nxt, ru_nxt;
  logic              rn_nxt, dz_nxt;

  assign x1 = au_a_r - irange_pkg::ONE;
  assign y1 = bu_a_r - irange_pkg::ONE;

  always_comb begin
    rl_nxt = irange_pkg::ZERO;
    ru_nxt = irange_pkg::ZERO;
    rn_nxt = 1'b0;
    dz_nxt = 1'b0;
    unique case (cmd_a_r)
      irange_pkg::CMD_ADD: begin
        if (an_a_r && bn_a_r) begin
          rn_nxt = 1'b1;
        end else if (an_a_r) begin
          rl_nxt = bl_a_r;
          ru_nxt = bu_a_r;
        end else if (bn_a_r) begin
          rl_nxt = al_a_r;
          ru_nxt = au_a_r;
        end else begin
          rl_nxt = al_a_r + bl_a_r;
          ru_nxt = au_a_r + y1;
        end
      end
      irange_pkg::CMD_SUB: begin
        if (an_a_r) begin
          rn_nxt = 1'b1;
        end else if (bn_a_r) begin
          rl_nxt = al_a_r;
          ru_nxt = au_a_r;
        end else begin
          rl_nxt = al_a_r - y1;
          ru_nxt = au_a_r - bl_a_r;
        end
      end
      irange_pkg::CMD_MUL: begin
        rn_nxt = an_a_r || bn_a_r;
      end
      irange_pkg::CMD_DIV: begin
        rn_nxt = an_a_r || bn_a_r;
        // zero divisor at either corner
        if (!rn_nxt && (bl_a_r == irange_pkg::ZERO || y1 == irange_pkg::ZERO)) begin
          dz_nxt = 1'b1;
          rn_nxt = 1'b1;
        end
      end
      default: begin
        rn_nxt = 1'b1;
      end
    endcase
  end

  logic                   v_b_r;
  irange_pkg::cmd_t       cmd_b_r;
  logic                   rn_b_r, dz_b_r;
  irange_pkg::word_t      rl_b_r, ru_b_r;
  irange_pkg::lane_word_t cx_b_r, cy_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_b_r <= 1'b0;
    end else if (en) begin
      v_b_r <= v_a_r;
    end
  end

  // lanes: x0*y0, x0*y1, x1*y0, x1*y1
  always_ff @(posedge clk) begin
    if (en) begin
      cmd_b_r <= cmd_a_r;
      rn_b_r  <= rn_nxt;
      dz_b_r  <= dz_nxt;
      rl_b_r  <= rl_nxt;
      ru_b_r  <= ru_nxt;
      cx_b_r  <= {x1, x1, al_a_r, al_a_r};
      cy_b_r  <= {y1, bl_a_r, y1, bl_a_r};
    end
  end

  // ---- stage c: corner products, divider operand magnitudes
  irange_pkg::lane_word_t prod_nxt, dvd_nxt, dvs_nxt;
  logic [irange_pkg::LANES-1:0] neg_nxt;

  always_comb begin
    for (int l = 0; l < irange_pkg::LANES; l++) begin
      // low word of the product is sign independent
      prod_nxt[l] = irange_pkg::word_t'(cx_b_r[l] * cy_b_r[l]);
      dvd_nxt[l]  = cx_b_r[l][irange_pkg::WORD-1] ? -cx_b_r[l] : cx_b_r[l];
      dvs_nxt[l]  = cy_b_r[l][irange_pkg::WORD-1] ? -cy_b_r[l] : cy_b_r[l];
      neg_nxt[l]  = cx_b_r[l][irange_pkg::WORD-1] ^ cy_b_r[l][irange_pkg::WORD-1];
    end
  end

  logic                   v_c_r;
  irange_pkg::side_t      side_c_r;
  irange_pkg::lane_word_t dvd_c_r, dvs_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_c_r <= 1'b0;
    end else if (en) begin
      v_c_r <= v_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_c_r <= '{cmd: cmd_b_r, rn: rn_b_r, dz: dz_b_r, rl: rl_b_r, ru: ru_b_r,
                    prod: prod_nxt, neg: neg_nxt};
      dvd_c_r  <= dvd_nxt;
      dvs_c_r  <= dvs_nxt;
    end
  end

  // ---- stages d: divider with matching sideband and valid delay line
  irange_pkg::lane_word_t quo;

  irange_div u_div (
    .clk   (clk),
    .en    (en),
    .dvd_i (dvd_c_r),
    .dvs_i (dvs_c_r),
    .quo_o (quo)
  );

  logic [irange_pkg::DIV_STAGES-1:0] v_d_r;
  irange_pkg::side_t                 side_d_r [irange_pkg::DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_d_r <= '0;
    end else if (en) begin
      v_d_r <= {v_d_r[irange_pkg::DIV_STAGES-2:0], v_c_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_d_r[0] <= side_c_r;
      for (int s = 1; s < irange_pkg::DIV_STAGES; s++) begin
        side_d_r[s] <= side_d_r[s-1];
      end
    end
  end

  // ---- stage e: signed quotients, pick corner set
  irange_pkg::side_t      side_e;
  irange_pkg::lane_word_t corner_nxt;

  assign side_e = side_d_r[irange_pkg::DIV_STAGES-1];

  always_comb begin
    for (int l = 0; l < irange_pkg::LANES; l++) begin
      if (side_e.cmd == irange_pkg::CMD_MUL) begin
        corner_nxt[l] = side_e.prod[l];
      end else begin
        // most negative over minus one wraps back to itself
        corner_nxt[l] = side_e.neg[l] ? -quo[l] : quo[l];
      end
    end
  end

  logic                   v_e_r;
  fin_t                   fin_e_r;
  irange_pkg::lane_word_t corner_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_e_r <= 1'b0;
    end else if (en) begin
      v_e_r <= v_d_r[irange_pkg::DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_e_r <= '{arith: (side_e.cmd == irange_pkg::CMD_MUL) ||
                          (side_e.cmd == irange_pkg::CMD_DIV),
                   rn: side_e.rn, dz: side_e.dz, rl: side_e.rl, ru: side_e.ru};
      corner_e_r <= corner_nxt;
    end
  end

  // ---- stage f: pairwise signed min and max
  logic              v_f_r;
  fin_t              fin_f_r;
  irange_pkg::word_t mn01_f_r, mx01_f_r, mn23_f_r, mx23_f_r;
  logic              lt01, lt23;

  assign lt01 = $signed(corner_e_r[0]) < $signed(corner_e_r[1]);
  assign lt23 = $signed(corner_e_r[2]) < $signed(corner_e_r[3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_f_r <= 1'b0;
    end else if (en) begin
      v_f_r <= v_e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_f_r  <= fin_e_r;
      mn01_f_r <= lt01 ? corner_e_r[0] : corner_e_r[1];
      mx01_f_r <= lt01 ? corner_e_r[1] : corner_e_r[0];
      mn23_f_r <= lt23 ? corner_e_r[2] : corner_e_r[3];
      mx23_f_r <= lt23 ? corner_e_r[3] : corner_e_r[2];
    end
  end

  // ---- stage g: final min, max+1 or add/sub bounds, null zeroing, output register
  irange_pkg::word_t mn, mx, res_lower_nxt, res_upper_nxt;

  assign mn = ($signed(mn01_f_r) < $signed(mn23_f_r)) ? mn01_f_r : mn23_f_r;
  assign mx = ($signed(mx01_f_r) > $signed(mx23_f_r)) ? mx01_f_r : mx23_f_r;

  always_comb begin
    if (fin_f_r.rn) begin
      res_lower_nxt = irange_pkg::ZERO;
      res_upper_nxt = irange_pkg::ZERO;
    end else if (fin_f_r.arith) begin
      res_lower_nxt = mn;
      res_upper_nxt = mx + irange_pkg::ONE;
    end else begin
      res_lower_nxt = fin_f_r.rl;
      res_upper_nxt = fin_f_r.ru;
    end
  end

  logic              v_g_r;
  logic              res_null_g_r, div_zero_g_r;
  irange_pkg::word_t res_lower_g_r, res_upper_g_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_g_r <= 1'b0;
    end else if (en) begin
      v_g_r <= v_f_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_null_g_r  <= fin_f_r.rn;
      div_zero_g_r  <= fin_f_r.dz;
      res_lower_g_r <= res_lower_nxt;
      res_upper_g_r <= res_upper_nxt;
    end
  end

  assign out_tvalid = v_g_r;
  assign out_tdata  = {6'd0, div_zero_g_r, res_upper_g_r, res_lower_g_r, res_null_g_r};

  // ---- checks
  a_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_null_g_r |-> res_lower_g_r == irange_pkg::ZERO &&
                                   res_upper_g_r == irange_pkg::ZERO)
    else $error("null result with nonzero bounds");

  a_dz_null: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && div_zero_g_r |-> res_null_g_r)
    else $error("zero divisor without null result");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_d_r) && $stable(v_e_r) && $stable(v_f_r))
    else $error("pipeline moved during stall");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output slot");

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for interval_range_alu_core
// directed table of range pairs, then random pairs with random gaps on both
// sides; every result is compared with an in-bench range predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int N_RANDOM  = 1130;
  localparam int LATENCY   = 38;

  typedef struct packed {
    logic              an;
    irange_pkg::word_t al;
    irange_pkg::word_t au;
    logic              bn;
    irange_pkg::word_t bl;
    irange_pkg::word_t bu;
  } range_pair_t;

  typedef struct packed {
    logic              rn;
    irange_pkg::word_t rl;
    irange_pkg::word_t ru;
    logic              dz;
  } range_res_t;

  // one directed row: operands, and an optional typed-in result
  typedef struct {
    irange_pkg::cmd_t cmd;
    range_pair_t      ops;
    bit               has_res;
    range_res_t       res;
  } vec_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [135:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [71:0]  out_tdata;

  range_res_t  range_expect_q[$];
  int          n_fail;
  int          n_results;
  int          n_sent;
  bit          hold_out;

  interval_range_alu_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ranges fold to min and max+1 of the four corners, compared as signed
  function automatic range_res_t fold_corners(irange_pkg::word_t c0, irange_pkg::word_t c1,
                                              irange_pkg::word_t c2, irange_pkg::word_t c3);
    irange_pkg::word_t c[4];
    irange_pkg::word_t mn;
    irange_pkg::word_t mx;
    range_res_t        r;
    c = '{c0, c1, c2, c3};
    mn = c[0];
    mx = c[0];
    for (int i = 1; i < 4; i++) begin
      if ($signed(c[i]) < $signed(mn)) mn = c[i];
      if ($signed(c[i]) > $signed(mx)) mx = c[i];
    end
    r = '0;
    r.rl = mn;
    r.ru = mx + irange_pkg::ONE;
    return r;
  endfunction

  // signed quotient truncating toward zero, most negative / -1 wraps
  function automatic irange_pkg::word_t quot(irange_pkg::word_t x, irange_pkg::word_t y);
    if (x == 32'h8000_0000 && y == 32'hFFFF_FFFF) return x;
    return irange_pkg::word_t'($signed(x) / $signed(y));
  endfunction

  function automatic range_res_t predict_range(irange_pkg::cmd_t cmd, range_pair_t p);
    range_res_t        r;
    irange_pkg::word_t x1;
    irange_pkg::word_t y1;
    r = '0;
    x1 = p.au - irange_pkg::ONE;
    y1 = p.bu - irange_pkg::ONE;
    case (cmd)
      irange_pkg::CMD_ADD: begin
        if (p.an && p.bn) r.rn = 1'b1;
        else if (p.an) begin r.rl = p.bl; r.ru = p.bu; end
        else if (p.bn) begin r.rl = p.al; r.ru = p.au; end
        else begin r.rl = p.al + p.bl; r.ru = p.au + p.bu - irange_pkg::ONE; end
      end
      irange_pkg::CMD_SUB: begin
        if (p.an) r.rn = 1'b1;
        else if (p.bn) begin r.rl = p.al; r.ru = p.au; end
        else begin r.rl = p.al - y1; r.ru = p.au - p.bl; end
      end
      irange_pkg::CMD_MUL: begin
        if (p.an || p.bn) r.rn = 1'b1;
        else r = fold_corners(p.al * p.bl, p.al * y1, x1 * p.bl, x1 * y1);
      end
      default: begin
        if (p.an || p.bn) r.rn = 1'b1;
        else if (p.bl == irange_pkg::ZERO || y1 == irange_pkg::ZERO) begin
          r.rn = 1'b1;
          r.dz = 1'b1;
        end else begin
          r = fold_corners(quot(p.al, p.bl), quot(p.al, y1), quot(x1, p.bl), quot(x1, y1));
        end
      end
    endcase
    if (r.rn) begin
      r.rl = irange_pkg::ZERO;
      r.ru = irange_pkg::ZERO;
    end
    return r;
  endfunction

  function automatic irange_pkg::word_t rand_bound();
    case ($urandom_range(0, 5))
      0:       return irange_pkg::word_t'($urandom_range(0, 8)) - irange_pkg::word_t'(4);
      1:       return 32'h8000_0000 + irange_pkg::word_t'($urandom_range(0, 2));
      2:       return 32'h7FFF_FFFF - irange_pkg::word_t'($urandom_range(0, 2));
      3:       return irange_pkg::word_t'($urandom_range(0, 2000)) -
                      irange_pkg::word_t'(1000);
      default: return irange_pkg::word_t'($urandom);
    endcase
  endfunction

  function automatic range_pair_t rand_pair();
    range_pair_t p;
    p.an = ($urandom_range(0, 9) == 0);
    p.bn = ($urandom_range(0, 9) == 0);
    p.al = rand_bound();
    p.bl = rand_bound();
    // mostly well-formed ranges, sometimes raw random bounds
    p.au = ($urandom_range(0, 3) != 0) ?
           p.al + irange_pkg::word_t'($urandom_range(1, 300)) : rand_bound();
    p.bu = ($urandom_range(0, 3) != 0) ?
           p.bl + irange_pkg::word_t'($urandom_range(1, 300)) : rand_bound();
    return p;
  endfunction

  // one input transaction, with a random idle gap before it unless bursting
  task automatic send_range(irange_pkg::cmd_t cmd, range_pair_t p, bit burst);
    int gap;
    gap = burst ? 0 :
          ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'd0, p.bu, p.bl, p.bn, p.au, p.al, p.an};
    range_expect_q.push_back(predict_range(cmd, p));
    do @(posedge clk); while (!in_tready);
    n_sent++;
  endtask

  // output-side ready: random stalls plus one long hold-off
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_tready <= 1'b0;
        repeat (120) @(posedge clk);
        hold_out = 1'b0;
      end else if ($urandom_range(0, 99) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(0, 9) < 7);
      end
    end
  end

  // result checker: compare each output transaction with the oldest prediction
  always @(posedge clk) begin
    range_res_t got;
    range_res_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got.rn = out_tdata[0];
      got.rl = out_tdata[32:1];
      got.ru = out_tdata[64:33];
      got.dz = out_tdata[65];
      n_results++;
      if (range_expect_q.size() == 0) begin
        $error("unexpected result transaction %h", got);
        n_fail++;
      end else begin
        exp_r = range_expect_q.pop_front();
        if (got.rn !== exp_r.rn) begin
          $error("res_null exp %0b got %0b", exp_r.rn, got.rn); n_fail++;
        end
        if (got.rl !== exp_r.rl) begin
          $error("res_lower exp %h got %h", exp_r.rl, got.rl); n_fail++;
        end
        if (got.ru !== exp_r.ru) begin
          $error("res_upper exp %h got %h", exp_r.ru, got.ru); n_fail++;
        end
        if (got.dz !== exp_r.dz) begin
          $error("div_zero exp %0b got %0b", exp_r.dz, got.dz); n_fail++;
        end
      end
    end
  end

  // directed table: extremes, each command, each null rule, zero divisor
  vec_row_t dir_tab[22] = '{
    '{irange_pkg::CMD_ADD, '{1'b1, 32'd5, 32'd9, 1'b1, 32'd1, 32'd2},
      1'b1, '{1'b1, 32'd0, 32'd0, 1'b0}},
    '{irange_pkg::CMD_ADD, '{1'b1, 32'd5, 32'd9, 1'b0, 32'd3, 32'd7},
      1'b1, '{1'b0, 32'd3, 32'd7, 1'b0}},
    '{irange_pkg::CMD_ADD, '{1'b0, 32'd5, 32'd9, 1'b1, 32'd3, 32'd7},
      1'b1, '{1'b0, 32'd5, 32'd9, 1'b0}},
    '{irange_pkg::CMD_ADD, '{1'b0, 32'd5, 32'd9, 1'b0, 32'd3, 32'd7},
      1'b1, '{1'b0, 32'd8, 32'd15, 1'b0}},
    '{irange_pkg::CMD_ADD,
      '{1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
      1'b0, '0},
    '{irange_pkg::CMD_ADD,
      '{1'b0, 32'h8000_0000, 32'h8000_0000, 1'b0, 32'hFFFF_FFFF, 32'h8000_0000},
      1'b0, '0},
    '{irange_pkg::CMD_SUB, '{1'b1, 32'd5, 32'd9, 1'b0, 32'd3, 32'd7},
      1'b1, '{1'b1, 32'd0, 32'd0, 1'b0}},
    '{irange_pkg::CMD_SUB, '{1'b1, 32'd5, 32'd9, 1'b1, 32'd3, 32'd7},
      1'b1, '{1'b1, 32'd0, 32'd0, 1'b0}},
    '{irange_pkg::CMD_SUB, '{1'b0, 32'd5, 32'd9, 1'b1, 32'd3, 32'd7},
      1'b1, '{1'b0, 32'd5, 32'd9, 1'b0}},
    '{irange_pkg::CMD_SUB, '{1'b0, 32'd5, 32'd9, 1'b0, 32'd3, 32'd7}, 1'b0, '0},
    '{irange_pkg::CMD_SUB,
      '{1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000},
      1'b0, '0},
    '{irange_pkg::CMD_MUL, '{1'b1, 32'd1, 32'd2, 1'b0, 32'd1, 32'd2},
      1'b1, '{1'b1, 32'd0, 32'd0, 1'b0}},
    '{irange_pkg::CMD_MUL, '{1'b0, 32'd1, 32'd2, 1'b1, 32'd1, 32'd2},
      1'b1, '{1'b1, 32'd0, 32'd0, 1'b0}},
    '{irange_pkg::CMD_MUL, '{1'b0, 32'hFFFF_FFFD, 32'd4, 1'b0, 32'hFFFF_FFFE, 32'd6},
      1'b0, '0},
    '{irange_pkg::CMD_MUL,
      '{1'b0, 32'h8000_0000, 32'h8000_0000, 1'b0, 32'h7FFF_FFFF, 32'hFFFF_FFFF},
      1'b0, '0},
    '{irange_pkg::CMD_DIV, '{1'b1, 32'd1, 32'd2, 1'b0, 32'd0, 32'd1},
      1'b1, '{1'b1, 32'd0, 32'd0, 1'b0}},
    '{irange_pkg::CMD_DIV, '{1'b0, 32'd1, 32'd2, 1'b1, 32'd0, 32'd1},
      1'b1, '{1'b1, 32'd0, 32'd0, 1'b0}},
    '{irange_pkg::CMD_DIV, '{1'b0, 32'd7, 32'd9, 1'b0, 32'd0, 32'd5},
      1'b1, '{1'b1, 32'd0, 32'd0, 1'b1}},
    '{irange_pkg::CMD_DIV, '{1'b0, 32'd7, 32'd9, 1'b0, 32'd3, 32'd1},
      1'b1, '{1'b1, 32'd0, 32'd0, 1'b1}},
    '{irange_pkg::CMD_DIV, '{1'b0, 32'hFFFF_FFF9, 32'd8, 1'b0, 32'd2, 32'd4},
      1'b0, '0},
    '{irange_pkg::CMD_DIV,
      '{1'b0, 32'h8000_0000, 32'h8000_0001, 1'b0, 32'hFFFF_FFFF, 32'd0},
      1'b1, '{1'b0, 32'h8000_0000, 32'h8000_0001, 1'b0}},
    '{irange_pkg::CMD_DIV,
      '{1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h8000_0000, 32'h8000_0001},
      1'b0, '0}
  };

  initial begin
    range_res_t typed;
    int         waited;
    n_fail = 0;
    n_results = 0;
    n_sent = 0;
    hold_out = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = irange_pkg::CMD_ADD;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      // typed-in rows also cross-check the predictor itself
      if (dir_tab[i].has_res) begin
        typed = predict_range(dir_tab[i].cmd, dir_tab[i].ops);
        if (typed !== dir_tab[i].res) begin
          $error("table row %0d exp %h predictor %h", i, dir_tab[i].res, typed);
          n_fail++;
        end
      end
      send_range(dir_tab[i].cmd, dir_tab[i].ops, 1'b0);
    end

    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == 300) hold_out = 1'b1;
      // back-to-back offers during the hold-off so the pipeline backs up
      send_range(irange_pkg::cmd_t'($urandom_range(0, 3)), rand_pair(),
                 (k >= 300 && k < 400));
    end
    in_tvalid <= 1'b0;

    waited = 0;
    while (range_expect_q.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (range_expect_q.size() != 0) begin
      $error("%0d results never arrived", range_expect_q.size());
      n_fail++;
    end
    $display("sent %0d range pairs over all four commands, %0d results checked",
             n_sent, n_results);
    $display("covered null rules, zero divisors, wraparound and a long output stall");
    if (n_fail == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
